// ----- sv/upc_pkg.sv -----
`default_nettype none
package upc_pkg;

	localparam int CountBits = 16;
	localparam int SumBits   = (CountBits + 1 > 17) ? CountBits + 1 : 17;

	localparam logic [1:0] StOk        = 2'd0;
	localparam logic [1:0] StBadEscape = 2'd1;
	localparam logic [1:0] StCapacity  = 2'd2;

	localparam logic [1:0] ModeForm = 2'd1;

	localparam logic RegMode     = 1'b0;
	localparam logic RegCapacity = 1'b1;

	localparam logic [1:0] PhIdle = 2'd0;
	localparam logic [1:0] PhHigh = 2'd1;
	localparam logic [1:0] PhLow  = 2'd2;

	localparam logic [7:0] ChPercent = 8'h25;
	localparam logic [7:0] ChPlus    = 8'h2B;
	localparam logic [7:0] ChSpace   = 8'h20;
	localparam logic [3:0] NibbleMask = 4'hF;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [15:0] capacity;
	} cfg_t;

	// one item's worth of results; per-beat last and length come from cnt
	typedef struct packed {
		logic [1:0]  cnt;
		logic [7:0]  b0;
		logic [7:0]  b1;
		logic [7:0]  b2;
		logic        valid;
		logic [1:0]  status;
		logic        last;
		logic [15:0] len;
	} res_t;

	function automatic logic [7:0] hex_digit(input logic [3:0] v);
		hex_digit = (v < 4'd10) ? (8'h30 + {4'd0, v}) : (8'h37 + {4'd0, v});
	endfunction

	function automatic logic is_unreserved(input logic [7:0] c);
		is_unreserved = c inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39],
			8'h2D, 8'h2E, 8'h5F, 8'h7E};
	endfunction

	// {ok, value}
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [7:0] t;
		t = 8'h00;
		hex_value = 5'd0;
		if (c inside {[8'h30:8'h39]}) begin
			t = c - 8'h30;
			hex_value = {1'b1, t[3:0]};
		end else if (c inside {[8'h41:8'h46]}) begin
			t = c - 8'h37;
			hex_value = {1'b1, t[3:0]};
		end else if (c inside {[8'h61:8'h66]}) begin
			t = c - 8'h57;
			hex_value = {1'b1, t[3:0]};
		end
	endfunction

endpackage
`default_nettype wire

// ----- sv/upc_in_reg.sv -----
`default_nettype none
module upc_in_reg (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  s_tvalid,
	output logic                 s_tready,
	input  wire  [7:0]           s_tdata,   // in_byte
	input  wire                  s_tlast,   // in_last
	input  wire                  take,
	output logic                 item_valid,
	output upc_pkg::in_item_t    item
);
	import upc_pkg::*;

	logic     valid_s1;
	in_item_t item_s1;

	assign s_tready   = !valid_s1 || take;
	assign item_valid = valid_s1;
	assign item       = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.data <= s_tdata;
			item_s1.last <= s_tlast;
		end
	end

endmodule
`default_nettype wire

// ----- sv/upc_engine.sv -----
`default_nettype none
module upc_engine (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  item_valid,
	input  wire upc_pkg::in_item_t item,
	input  wire upc_pkg::cfg_t   cfg,
	input  wire                  buf_free,
	output logic                 take,
	output upc_pkg::res_t        res
);
	import upc_pkg::*;

	logic [1:0]           phase_q, phase_d;
	logic [3:0]           nib_q, nib_d;
	logic [CountBits-1:0] pc_q, pc_d;
	logic                 drop_q, drop_d;

	logic [7:0]         c;
	logic               last;
	logic [4:0]         hv;
	logic [1:0]         n;
	logic [SumBits-1:0] sum;
	logic [SumBits-1:0] pc_x;
	logic [SumBits-1:0] cap_x;
	logic [SumBits-1:0] cnt_max;
	logic               fail;
	logic [1:0]         fail_st;

	assign c       = item.data;
	assign last    = item.last;
	assign hv      = hex_value(c);
	assign pc_x    = SumBits'(pc_q);
	assign cap_x   = SumBits'(cfg.capacity);
	assign cnt_max = SumBits'({CountBits{1'b1}});

	always_comb begin
		phase_d = phase_q;
		nib_d   = nib_q;
		pc_d    = pc_q;
		drop_d  = drop_q;
		n       = 2'd0;
		fail    = 1'b0;
		fail_st = StOk;
		res     = '0;
		sum     = pc_x;

		if (drop_q) begin
			if (last) begin
				drop_d  = 1'b0;
				phase_d = PhIdle;
				nib_d   = 4'd0;
				pc_d    = '0;
			end
		end else if (cfg.mode[1]) begin
			case (phase_q)
				PhIdle: begin
					if (c == ChPercent) begin
						if (last) begin
							fail    = 1'b1;
							fail_st = StBadEscape;
						end else begin
							phase_d = PhHigh;
						end
					end else begin
						n      = 2'd1;
						res.b0 = c;
					end
				end
				PhHigh: begin
					if (!hv[4] || last) begin
						fail    = 1'b1;
						fail_st = StBadEscape;
					end else begin
						nib_d   = hv[3:0];
						phase_d = PhLow;
					end
				end
				default: begin
					if (!hv[4]) begin
						fail    = 1'b1;
						fail_st = StBadEscape;
					end else begin
						n       = 2'd1;
						res.b0  = {nib_q & NibbleMask, hv[3:0]};
						phase_d = PhIdle;
					end
				end
			endcase
			sum = pc_x + SumBits'(n);
			if (n != 2'd0 && (pc_x >= cap_x || sum > cnt_max)) begin
				fail    = 1'b1;
				fail_st = StCapacity;
			end
		end else begin
			if (is_unreserved(c)) begin
				n      = 2'd1;
				res.b0 = c;
			end else if (cfg.mode == ModeForm && c == ChSpace) begin
				n      = 2'd1;
				res.b0 = ChPlus;
			end else begin
				n      = 2'd3;
				res.b0 = ChPercent;
				res.b1 = hex_digit(c[7:4]);
				res.b2 = hex_digit(c[3:0]);
			end
			sum = pc_x + SumBits'(n);
			if (sum >= cap_x || sum > cnt_max) begin
				fail    = 1'b1;
				fail_st = StCapacity;
			end
		end

		if (fail) begin
			res     = '0;
			res.cnt = 2'd1;
			res.status = fail_st;
			res.last   = 1'b1;
			phase_d = PhIdle;
			nib_d   = 4'd0;
			pc_d    = '0;
			drop_d  = !last;
		end else if (!drop_q) begin
			res.cnt   = n;
			res.valid = 1'b1;
			res.last  = last;
			res.len   = last ? sum[15:0] : 16'd0;
			pc_d      = sum[CountBits-1:0];
			if (last) begin
				phase_d = PhIdle;
				nib_d   = 4'd0;
				pc_d    = '0;
			end
		end
	end

	assign take = item_valid && (res.cnt == 2'd0 || buf_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PhIdle;
			nib_q   <= 4'd0;
			pc_q    <= '0;
			drop_q  <= 1'b0;
		end else if (take) begin
			phase_q <= phase_d;
			nib_q   <= nib_d;
			pc_q    <= pc_d;
			drop_q  <= drop_d;
		end
	end

endmodule
`default_nettype wire

// ----- sv/upc_serializer.sv -----
`default_nettype none
module upc_serializer (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                load,
	input  wire upc_pkg::res_t res,
	output logic               buf_free,
	output logic               m_tvalid,
	input  wire                m_tready,
	output logic [23:0]        m_tdata,   // out_byte, out_length
	output logic [2:0]         m_tuser,   // out_valid, status
	output logic               m_tlast    // out_last
);
	import upc_pkg::*;

	res_t       buf_s2;
	logic       valid_s2;
	logic [1:0] idx_q;
	logic       final_beat;
	logic [7:0] beat_byte;

	assign final_beat = (idx_q == buf_s2.cnt - 2'd1);
	assign buf_free   = !valid_s2 || (m_tready && final_beat);

	always_comb begin
		case (idx_q)
			2'd0:    beat_byte = buf_s2.b0;
			2'd1:    beat_byte = buf_s2.b1;
			default: beat_byte = buf_s2.b2;
		endcase
	end

	assign m_tvalid = valid_s2;
	assign m_tlast  = buf_s2.last && final_beat;
	assign m_tdata  = {(m_tlast ? buf_s2.len : 16'd0), beat_byte};
	assign m_tuser  = {buf_s2.status, buf_s2.valid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_q    <= 2'd0;
		end else if (buf_free) begin
			valid_s2 <= load;
			idx_q    <= 2'd0;
		end else if (m_tready) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (buf_free && load) begin
			buf_s2 <= res;
		end
	end

endmodule
`default_nettype wire

// ----- sv/url_percent_codec_top.sv -----
// An accepted input beat is registered in u_in; its results are then registered in u_ser.
// Throughput: one input beat per cycle when it yields at most one result and m_tready
// stays high; an escaped byte holds the output register for its three result beats (one per cycle).
// Bytes that yield nothing (the percent sign and high digit of an escape, dropped input) skip the output buffer.
// Reset (arst_n low, async): pipeline empty, mode 0, capacity 65535, string state clear.
`default_nettype none
module url_percent_codec_top (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [7:0]  s_tdata,    // in_byte
	input  wire         s_tlast,    // in_last
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [23:0] m_tdata,    // out_byte[7:0], out_length[23:8]
	output logic [2:0]  m_tuser,    // out_valid[0], status[2:1]
	output logic        m_tlast,    // out_last
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire         cfg_index,
	input  wire  [15:0] cfg_data
);
	import upc_pkg::*;

	cfg_t     cfg_q;
	in_item_t item;
	res_t     res;
	logic     item_valid;
	logic     take;
	logic     buf_free;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode     <= 2'd0;
			cfg_q.capacity <= 16'hFFFF;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				RegMode:     cfg_q.mode     <= cfg_data[1:0];
				RegCapacity: cfg_q.capacity <= cfg_data;
				default:     ;
			endcase
		end
	end

	upc_in_reg u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.take       (take),
		.item_valid (item_valid),
		.item       (item)
	);

	upc_engine u_eng (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.cfg        (cfg_q),
		.buf_free   (buf_free),
		.take       (take),
		.res        (res)
	);

	upc_serializer u_ser (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (take && res.cnt != 2'd0),
		.res      (res),
		.buf_free (buf_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
`default_nettype wire

// ----- bench/url_percent_codec_top_test.sv -----
`default_nettype none
module url_percent_codec_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import upc_pkg::*;

	localparam logic [1:0] ModePercent   = 2'd0;
	localparam logic [1:0] ModeDecode    = 2'd2;
	localparam logic [1:0] ModeDecodeAlt = 2'd3;
	localparam int CountMax    = (1 << CountBits) - 1;
	localparam int RandomItems = 480;
	localparam int CycleLimit  = 500000;
	localparam string PlainSet =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-._~";

	typedef struct {
		logic [7:0]  ch;
		logic        has_data;
		logic [1:0]  status;
		logic        last;
		logic [15:0] len;
	} codec_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        m_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = RegMode;
	logic [15:0] cfg_data = 16'h0000;

	url_percent_codec_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// codec state as the block should hold it
	logic [1:0]  codec_mode = ModePercent;
	logic [15:0] codec_cap = 16'hFFFF;
	logic [1:0]  esc_phase = PhIdle;
	logic [3:0]  hi_nib = 4'h0;
	int          out_count = 0;
	bit          dropping = 1'b0;

	in_item_t    src_items[$];
	codec_beat_t expected_beats[$];
	int          src_gap = 0;
	int          sink_gap = 0;
	bit          quiet = 1'b0;
	int          err_count = 0;
	int          queued_items = 0;
	int          in_beats = 0;
	int          out_beats = 0;
	int          status_beats = 0;
	int          settings = 0;
	int          cycles = 0;

	function automatic int hex_val(logic [7:0] c);
		if (c >= "0" && c <= "9")
			return int'(c) - int'("0");
		if (c >= "a" && c <= "f")
			return int'(c) - int'("a") + 10;
		if (c >= "A" && c <= "F")
			return int'(c) - int'("A") + 10;
		return -1;
	endfunction

	function automatic logic [7:0] hex_char(logic [3:0] v, bit lower);
		if (v < 4'd10)
			return 8'("0") + 8'(v);
		return (lower ? 8'("a") : 8'("A")) + 8'(v) - 8'd10;
	endfunction

	function automatic bit plain_char(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
			(c >= "0" && c <= "9") || c == "-" || c == "." || c == "_" || c == "~";
	endfunction

	function automatic void clear_string();
		esc_phase = PhIdle;
		hi_nib = 4'h0;
		out_count = 0;
	endfunction

	function automatic void codec_error(logic [1:0] st, bit is_last);
		expected_beats.push_back('{8'h00, 1'b0, st, 1'b1, 16'd0});
		clear_string();
		dropping = !is_last;
	endfunction

	function automatic void predict_codec(logic [7:0] c, bit is_last);
		logic [7:0] outb [3];
		int n;
		int hv;
		n = 0;
		if (dropping) begin
			if (is_last) begin
				dropping = 1'b0;
				clear_string();
			end
			return;
		end
		if (codec_mode[1]) begin
			if (esc_phase == PhIdle) begin
				if (c == ChPercent) begin
					if (is_last)
						codec_error(StBadEscape, is_last);
					else
						esc_phase = PhHigh;
					return;
				end
				outb[0] = c;
				n = 1;
			end else if (esc_phase == PhHigh) begin
				hv = hex_val(c);
				if (hv < 0 || is_last) begin
					codec_error(StBadEscape, is_last);
					return;
				end
				hi_nib = hv[3:0];
				esc_phase = PhLow;
				return;
			end else begin
				hv = hex_val(c);
				if (hv < 0) begin
					codec_error(StBadEscape, is_last);
					return;
				end
				outb[0] = {hi_nib, hv[3:0]};
				n = 1;
				esc_phase = PhIdle;
			end
			if (out_count >= int'(codec_cap) || out_count + 1 > CountMax) begin
				codec_error(StCapacity, is_last);
				return;
			end
		end else begin
			// a pending escape phase is left alone by the encoders
			if (plain_char(c)) begin
				outb[0] = c;
				n = 1;
			end else if (codec_mode == ModeForm && c == ChSpace) begin
				outb[0] = ChPlus;
				n = 1;
			end else begin
				outb[0] = ChPercent;
				outb[1] = hex_char(c[7:4], 1'b0);
				outb[2] = hex_char(c[3:0], 1'b0);
				n = 3;
			end
			if (out_count + n >= int'(codec_cap) || out_count + n > CountMax) begin
				codec_error(StCapacity, is_last);
				return;
			end
		end
		for (int i = 0; i < n; i++) begin
			out_count++;
			if (is_last && i == n - 1)
				expected_beats.push_back('{outb[i], 1'b1, StOk, 1'b1, 16'(out_count)});
			else
				expected_beats.push_back('{outb[i], 1'b1, StOk, 1'b0, 16'd0});
		end
		if (is_last)
			clear_string();
	endfunction

	// mostly back to back, some short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 70)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 30);
	endfunction

	function automatic void check_field(string name, int exp_val, int got_val);
		if (exp_val != got_val) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, exp_val, got_val);
			err_count++;
		end
	endfunction

	// source side driver
	always @(posedge clk or negedge arst_n) begin
		in_item_t item;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= 8'h00;
			s_tlast <= 1'b0;
			src_gap = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_codec(s_tdata, s_tlast);
				in_beats++;
			end
			if (!s_tvalid || s_tready) begin
				if (src_gap > 0) begin
					src_gap--;
					s_tvalid <= 1'b0;
				end else if (src_items.size() != 0) begin
					item = src_items.pop_front();
					s_tdata <= item.data;
					s_tlast <= item.last;
					s_tvalid <= 1'b1;
					src_gap = pick_gap();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result side monitor
	always @(posedge clk or negedge arst_n) begin
		codec_beat_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			sink_gap = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				out_beats++;
				if (!m_tuser[0])
					status_beats++;
				if (expected_beats.size() == 0) begin
					$error("result beat with nothing expected: data 0x%0h user 0x%0h",
						m_tdata, m_tuser);
					err_count++;
				end else begin
					want = expected_beats.pop_front();
					check_field("out_byte", want.ch, m_tdata[7:0]);
					check_field("out_valid", want.has_data, m_tuser[0]);
					check_field("status", want.status, m_tuser[2:1]);
					check_field("out_last", want.last, m_tlast);
					check_field("out_length", want.len, m_tdata[23:8]);
				end
			end
			if (sink_gap > 0) begin
				sink_gap--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				sink_gap = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("Timeout after %0d cycles, %0d results still expected", cycles,
				expected_beats.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic push_item(logic [7:0] c, bit is_last);
		src_items.push_back('{c, is_last});
		queued_items++;
	endtask

	task automatic push_text(string s, bit end_last);
		for (int i = 0; i < s.len(); i++)
			push_item(s[i], end_last && i == s.len() - 1);
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (src_items.size() != 0 || s_tvalid || expected_beats.size() != 0);
		// digits and dropped bytes give no beat, let them settle
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(logic idx, logic [15:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == RegMode)
			codec_mode = val[1:0];
		else
			codec_cap = val;
		settings++;
	endtask

	task automatic queue_encode_string(bit finish);
		int len;
		int r;
		logic [7:0] c;
		len = $urandom_range(1, 10);
		for (int i = 0; i < len; i++) begin
			r = $urandom_range(0, 99);
			if (r < 50)
				c = PlainSet[$urandom_range(0, PlainSet.len() - 1)];
			else if (r < 62)
				c = ChSpace;
			else
				c = 8'($urandom_range(0, 255));
			push_item(c, finish && i == len - 1);
		end
	endtask

	task automatic queue_decode_string(bit finish);
		int tokens;
		int r;
		bit tail;
		bit short_esc;
		logic [7:0] c;
		logic [7:0] v;
		tokens = $urandom_range(1, 8);
		for (int t = 0; t < tokens; t++) begin
			tail = finish && t == tokens - 1;
			r = $urandom_range(0, 99);
			v = 8'($urandom_range(0, 255));
			if (r < 40) begin
				do
					c = 8'($urandom_range(0, 255));
				while (c == ChPercent);
				push_item(c, tail);
			end else if (r < 85) begin
				push_item(ChPercent, 1'b0);
				push_item(hex_char(v[7:4], 1'($urandom_range(0, 1))), 1'b0);
				push_item(hex_char(v[3:0], 1'($urandom_range(0, 1))), tail);
			end else if (r < 93) begin
				// non-hex digit in the high or the low place
				push_item(ChPercent, 1'b0);
				if ($urandom_range(0, 1))
					push_item(hex_char(v[7:4], 1'b0), 1'b0);
				do
					c = 8'($urandom_range(0, 255));
				while (hex_val(c) >= 0);
				push_item(c, tail);
			end else begin
				// escape cut short
				short_esc = 1'($urandom_range(0, 1));
				push_item(ChPercent, tail && short_esc);
				if (!short_esc)
					push_item(hex_char(v[3:0], 1'b1), tail);
			end
		end
	endtask

	initial begin
		int rand_start;
		int strings;
		int r;
		bit finish;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// percent encoding: unreserved bytes, byte extremes, space
		write_reg(RegMode, {14'd0, ModePercent});
		write_reg(RegCapacity, 16'hFFFF);
		push_text("Az0~", 1'b0);
		push_item(8'h00, 1'b0);
		push_item(8'hFF, 1'b0);
		push_item(ChSpace, 1'b1);
		wait_drained();

		// form encoding: space becomes plus, plus gets escaped
		write_reg(RegMode, {14'd0, ModeForm});
		push_text(" +", 1'b1);
		wait_drained();

		// decoding: lowercase digit, bad digit with drop, truncated escapes
		write_reg(RegMode, {14'd0, ModeDecode});
		push_text("%4ax", 1'b1);
		push_text("%gq", 1'b1);
		push_text("%", 1'b1);
		push_text("%4", 1'b1);
		wait_drained();

		// capacity zero and one, error on the last byte
		write_reg(RegMode, {14'd0, ModeDecodeAlt});
		write_reg(RegCapacity, 16'd0);
		push_text("a", 1'b1);
		wait_drained();
		write_reg(RegCapacity, 16'd1);
		push_text("ab", 1'b1);
		wait_drained();

		// mode switch while an escape is pending
		write_reg(RegCapacity, 16'hFFFF);
		write_reg(RegMode, {14'd0, ModeDecode});
		push_text("%", 1'b0);
		wait_drained();
		write_reg(RegMode, {14'd0, ModePercent});
		push_text("/", 1'b1);
		wait_drained();

		rand_start = queued_items;
		while (queued_items - rand_start < RandomItems) begin
			quiet = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 3) != 0 || queued_items == rand_start)
				write_reg(RegMode, {14'($urandom_range(0, 16383)), 2'($urandom_range(0, 3))});
			if ($urandom_range(0, 1) || queued_items == rand_start) begin
				r = $urandom_range(0, 99);
				if (r < 45)
					write_reg(RegCapacity, 16'hFFFF);
				else if (r < 85)
					write_reg(RegCapacity, 16'($urandom_range(0, 40)));
				else
					write_reg(RegCapacity, 16'($urandom_range(41, 65534)));
			end
			strings = $urandom_range(3, 8);
			for (int s = 0; s < strings; s++) begin
				// sometimes leave a string open across the next register write
				finish = !(s == strings - 1 && $urandom_range(0, 5) == 0);
				if (codec_mode[1])
					queue_decode_string(finish);
				else
					queue_encode_string(finish);
			end
			wait_drained();
		end
		quiet = 1'b0;
		wait_drained();

		$display("Ran %0d source beats through %0d register writes in all four modes,",
			in_beats, settings);
		$display("checked %0d result beats, %0d of them error status.", out_beats,
			status_beats);
		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
`default_nettype wire

// ----- filelist.f -----
sv/upc_pkg.sv
sv/upc_in_reg.sv
sv/upc_engine.sv
sv/upc_serializer.sv
sv/url_percent_codec_top.sv
bench/url_percent_codec_top_test.sv
